### rtl/core/mnbc_pkg.sv
// ---------------------------------------------------------------------------
// Mesh node boundary classifier package
// Shared constants, control word layout, microprogram and direction table.
// ---------------------------------------------------------------------------
package mnbc_pkg;

   // Grid geometry.
   localparam int MAX_DIM = 64;
   localparam int COORD_W = $clog2(MAX_DIM);
   localparam int DIM_W   = COORD_W + 1;
   localparam int ADDR_W  = 3 * COORD_W;
   localparam int DIR_W   = 6;
   localparam int STEP_W  = 5;
   localparam int NBR_W   = 5;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_Z = 2'd2;

   // Result kinds.
   localparam int KIND_W = 3;
   localparam logic [KIND_W-1:0] KIND_LOAD_DONE = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INSIDE    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NONE      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_REENTRANT = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SINGLE    = 3'd4;

   // Request commands.
   localparam logic CMD_LOAD     = 1'b0;
   localparam logic CMD_CLASSIFY = 1'b1;

   // Direction bits.
   localparam logic [DIR_W-1:0] DIR_NX = 6'b000001;
   localparam logic [DIR_W-1:0] DIR_PX = 6'b000010;
   localparam logic [DIR_W-1:0] DIR_NY = 6'b000100;
   localparam logic [DIR_W-1:0] DIR_PY = 6'b001000;
   localparam logic [DIR_W-1:0] DIR_NZ = 6'b010000;
   localparam logic [DIR_W-1:0] DIR_PZ = 6'b100000;

   // Microprogram step holding the last probe; face and edge classes end earlier.
   localparam logic [STEP_W-1:0] STEP_FACE_END = 5'd7;
   localparam logic [STEP_W-1:0] STEP_EDGE_END = 5'd19;
   localparam logic [STEP_W-1:0] STEP_LAST     = 5'd27;

   typedef enum logic [1:0] {
      OP_ENTRY,
      OP_SELF_CHECK,
      OP_PROBE
   } uop_type;

   typedef struct packed {
      uop_type            op;
      logic               issue;
      logic [NBR_W-1:0]   nbr;
      logic               class_end;
      logic               last;
   } ctl_word_type;

   typedef struct packed {
      logic         start;
      logic         run;
      ctl_word_type word;
   } seq_ctl_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_HOLD
   } seq_state_type;

   // Microprogram ROM. Step 0 enters the item, step 1 checks the node itself
   // and issues the first neighbor read, later steps accumulate the previous
   // neighbor and, all but the last, issue the next one.
   function automatic ctl_word_type mnbc_rom(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      w.op        = OP_PROBE;
      w.issue     = 1'b0;
      w.nbr       = '0;
      w.class_end = 1'b0;
      w.last      = 1'b0;
      case (step)
         5'd0: begin
            w.op = OP_ENTRY;
         end
         5'd1: begin
            w.op    = OP_SELF_CHECK;
            w.issue = 1'b1;
         end
         default: begin
            w.op        = OP_PROBE;
            w.issue     = (step < STEP_LAST);
            w.nbr       = NBR_W'(step - 5'd1);
            w.class_end = (step == STEP_FACE_END) || (step == STEP_EDGE_END) ||
                          (step >= STEP_LAST);
            w.last      = (step >= STEP_LAST);
         end
      endcase
      return w;
   endfunction

   // Neighbor directions in probe order: faces, edges, corners.
   function automatic logic [DIR_W-1:0] mnbc_dir(input logic [NBR_W-1:0] nbr);
      logic [DIR_W-1:0] m;
      case (nbr)
         5'd0:  m = DIR_NX;
         5'd1:  m = DIR_PX;
         5'd2:  m = DIR_NY;
         5'd3:  m = DIR_PY;
         5'd4:  m = DIR_NZ;
         5'd5:  m = DIR_PZ;
         5'd6:  m = DIR_NX | DIR_NY;
         5'd7:  m = DIR_NX | DIR_PY;
         5'd8:  m = DIR_PX | DIR_NY;
         5'd9:  m = DIR_PX | DIR_PY;
         5'd10: m = DIR_NX | DIR_NZ;
         5'd11: m = DIR_NX | DIR_PZ;
         5'd12: m = DIR_PX | DIR_NZ;
         5'd13: m = DIR_PX | DIR_PZ;
         5'd14: m = DIR_NY | DIR_NZ;
         5'd15: m = DIR_NY | DIR_PZ;
         5'd16: m = DIR_PY | DIR_NZ;
         5'd17: m = DIR_PY | DIR_PZ;
         5'd18: m = DIR_NX | DIR_NY | DIR_NZ;
         5'd19: m = DIR_NX | DIR_NY | DIR_PZ;
         5'd20: m = DIR_NX | DIR_PY | DIR_NZ;
         5'd21: m = DIR_NX | DIR_PY | DIR_PZ;
         5'd22: m = DIR_PX | DIR_NY | DIR_NZ;
         5'd23: m = DIR_PX | DIR_NY | DIR_PZ;
         5'd24: m = DIR_PX | DIR_PY | DIR_NZ;
         5'd25: m = DIR_PX | DIR_PY | DIR_PZ;
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

### rtl/core/mnbc_map_ram.sv
// ---------------------------------------------------------------------------
// Inside map RAM
// Single-port one-bit store, one entry per grid node, registered read data.
// ---------------------------------------------------------------------------
module mnbc_map_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [mnbc_pkg::ADDR_W-1:0] addr,
   input  logic                       wr_data,
   output logic                       rd_data
);
   import mnbc_pkg::*;

   logic mem [2**ADDR_W];
   logic rd_data_ff;

   // One access per cycle: a write, or a read into the output register.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mnbc_sequencer.sv
// ---------------------------------------------------------------------------
// Classifier sequencer
// Step counter over the microprogram ROM, with early exit on the finish flag.
// ---------------------------------------------------------------------------
module mnbc_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  logic                  fin,
   input  logic                  out_free,
   output logic                  ready,
   output logic                  push,
   output mnbc_pkg::seq_ctl_type ctl
);
   import mnbc_pkg::*;

   seq_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (req_accept) state_in = SEQ_RUN;
         SEQ_RUN:  if (fin) state_in = SEQ_HOLD;
         SEQ_HOLD: if (out_free) state_in = SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // Step counter restarts on every new request.
   always_comb begin
      step_in = step_ff;
      if (state_ff == SEQ_RUN) begin
         step_in = step_ff + 5'd1;
      end else begin
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Outputs.
   always_comb begin
      ready     = 1'b0;
      push      = 1'b0;
      ctl.start = req_accept;
      ctl.run   = 1'b0;
      ctl.word  = mnbc_rom(step_ff);
      unique case (state_ff)
         SEQ_IDLE: ready = 1'b1;
         SEQ_RUN:  ctl.run = 1'b1;
         SEQ_HOLD: push = out_free;
         default:  ready = 1'b0;
      endcase
   end

endmodule

### rtl/core/mnbc_datapath.sv
// ---------------------------------------------------------------------------
// Classifier datapath
// Node registers, neighbor address and bounds, class counting and result.
// ---------------------------------------------------------------------------
module mnbc_datapath (
   input  logic                        clock,
   input  mnbc_pkg::seq_ctl_type       ctl,
   input  logic                        req_command,
   input  logic [mnbc_pkg::COORD_W-1:0] req_x,
   input  logic [mnbc_pkg::COORD_W-1:0] req_y,
   input  logic [mnbc_pkg::COORD_W-1:0] req_z,
   input  logic                        req_flag,
   input  logic [mnbc_pkg::DIM_W-1:0]  dim_x,
   input  logic [mnbc_pkg::DIM_W-1:0]  dim_y,
   input  logic [mnbc_pkg::DIM_W-1:0]  dim_z,
   input  logic                        rd_data,
   output logic                        wr_en,
   output logic [mnbc_pkg::ADDR_W-1:0] addr,
   output logic                        wr_data,
   output logic                        fin,
   output logic [mnbc_pkg::KIND_W-1:0] kind,
   output logic [mnbc_pkg::DIR_W-1:0]  mask
);
   import mnbc_pkg::*;

   logic               cmd_ff;
   logic [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic               flag_ff;
   logic [1:0]         found_ff, found_in;
   logic [DIR_W-1:0]   fmask_ff, fmask_in;
   logic               pend_ok_ff, pend_ok_in;
   logic [DIR_W-1:0]   pend_mask_ff, pend_mask_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [DIR_W-1:0]   mask_ff, mask_in;

   logic               on_grid;
   logic [DIR_W-1:0]   nmask;
   logic [COORD_W-1:0] ax, ay, az;
   logic               ax_ok, ay_ok, az_ok, nbr_ok;
   logic [ADDR_W-1:0]  self_addr, nbr_addr;
   logic               hit;
   logic [1:0]         found_sum;
   logic [DIR_W-1:0]   fmask_sum;

   // Node bounds and flat address x + MAX_DIM*(y + MAX_DIM*z).
   assign on_grid   = ({1'b0, x_ff} < dim_x) && ({1'b0, y_ff} < dim_y) &&
                      ({1'b0, z_ff} < dim_z);
   assign self_addr = {z_ff, y_ff, x_ff};

   // Neighbor coordinates; an axis that steps off either edge marks it invalid.
   assign nmask = mnbc_dir(ctl.word.nbr);
   assign ax = nmask[1] ? x_ff + 1'b1 : (nmask[0] ? x_ff - 1'b1 : x_ff);
   assign ay = nmask[3] ? y_ff + 1'b1 : (nmask[2] ? y_ff - 1'b1 : y_ff);
   assign az = nmask[5] ? z_ff + 1'b1 : (nmask[4] ? z_ff - 1'b1 : z_ff);
   assign ax_ok = !(nmask[0] && (x_ff == '0)) &&
                  !(nmask[1] && (({1'b0, x_ff} + 7'd1) >= dim_x));
   assign ay_ok = !(nmask[2] && (y_ff == '0)) &&
                  !(nmask[3] && (({1'b0, y_ff} + 7'd1) >= dim_y));
   assign az_ok = !(nmask[4] && (z_ff == '0)) &&
                  !(nmask[5] && (({1'b0, z_ff} + 7'd1) >= dim_z));
   assign nbr_ok   = ax_ok && ay_ok && az_ok;
   assign nbr_addr = {az, ay, ax};

   // Count of inside neighbors in the current class, saturating at two.
   assign hit       = pend_ok_ff && rd_data;
   assign found_sum = (found_ff == 2'd2) ? 2'd2 : found_ff + {1'b0, hit};
   assign fmask_sum = hit ? pend_mask_ff : fmask_ff;

   // Micro-operation decode.
   always_comb begin
      wr_en        = 1'b0;
      wr_data      = flag_ff;
      addr         = self_addr;
      fin          = 1'b0;
      found_in     = found_ff;
      fmask_in     = fmask_ff;
      pend_ok_in   = 1'b0;
      pend_mask_in = nmask;
      kind_in      = kind_ff;
      mask_in      = mask_ff;
      if (ctl.run) begin
         unique case (ctl.word.op)
            OP_ENTRY: begin
               if (cmd_ff == CMD_LOAD) begin
                  wr_en   = on_grid;
                  fin     = 1'b1;
                  kind_in = KIND_LOAD_DONE;
                  mask_in = '0;
               end else if (!on_grid) begin
                  fin     = 1'b1;
                  kind_in = KIND_NONE;
                  mask_in = '0;
               end
            end
            OP_SELF_CHECK: begin
               found_in = '0;
               fmask_in = '0;
               if (rd_data) begin
                  fin     = 1'b1;
                  kind_in = KIND_INSIDE;
                  mask_in = '0;
               end else begin
                  addr       = nbr_addr;
                  pend_ok_in = nbr_ok;
               end
            end
            OP_PROBE: begin
               found_in = found_sum;
               fmask_in = fmask_sum;
               if (ctl.word.issue) begin
                  addr       = nbr_addr;
                  pend_ok_in = nbr_ok;
               end
               if (ctl.word.class_end) begin
                  if (found_sum == 2'd1) begin
                     fin     = 1'b1;
                     kind_in = KIND_SINGLE;
                     mask_in = fmask_sum;
                  end else if (found_sum == 2'd2) begin
                     fin     = 1'b1;
                     kind_in = KIND_REENTRANT;
                     mask_in = '0;
                  end else begin
                     found_in = '0;
                     if (ctl.word.last) begin
                        fin     = 1'b1;
                        kind_in = KIND_NONE;
                        mask_in = '0;
                     end
                  end
               end
            end
            default: fin = 1'b0;
         endcase
      end
   end

   // Request capture and working registers.
   always_ff @(posedge clock) begin
      if (ctl.start) begin
         cmd_ff  <= req_command;
         x_ff    <= req_x;
         y_ff    <= req_y;
         z_ff    <= req_z;
         flag_ff <= req_flag;
      end
      found_ff     <= found_in;
      fmask_ff     <= fmask_in;
      pend_ok_ff   <= pend_ok_in;
      pend_mask_ff <= pend_mask_in;
      kind_ff      <= kind_in;
      mask_ff      <= mask_in;
   end

   assign kind = kind_ff;
   assign mask = mask_ff;

endmodule

### rtl/core/mesh_node_boundary_classifier.sv
// ---------------------------------------------------------------------------
// Mesh node boundary classifier
// Grid of inside flags with load and neighbor-based boundary classification.
// ---------------------------------------------------------------------------
// One request is handled at a time. A load finishes at node entry, as does a
// classify for a node off the grid; an inside node finishes at the self check,
// and an outside node probes its neighbors one by one through the single-port
// inside map RAM, which serves one flag per cycle, stepped by a 28-step
// microprogram: node entry, self check, then 26 neighbor probes with exits at
// the end of the face, edge and corner classes. A finished response waits in
// an output register; the block returns to accepting requests once that
// register is free. Write the dimensions only while no request is in flight,
// since the sizes feed the bounds checks directly.
module mesh_node_boundary_classifier (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [23:0]                  req_tdata,  // node_x[5:0], node_y[11:6],
                                                    // node_z[17:12], inside_flag[18]
   input  logic                         req_tuser,  // command
   // Response channel.
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [7:0]                   rsp_tdata,  // direction_mask[5:0]
   output logic [mnbc_pkg::KIND_W-1:0]  rsp_tuser,  // kind
   // Configuration port.
   input  logic                         csr_we,
   input  logic [mnbc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mnbc_pkg::DIM_W-1:0]   csr_wdata
);
   import mnbc_pkg::*;

   logic [DIM_W-1:0]  dim_x_ff, dim_y_ff, dim_z_ff;
   logic [DIM_W-1:0]  eff_x, eff_y, eff_z;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [KIND_W-1:0] rsp_kind_ff;
   logic [DIR_W-1:0]  rsp_mask_ff;
   logic              req_accept, out_free, push, fin;
   logic              ram_we, ram_wdata, ram_rdata;
   logic [ADDR_W-1:0] ram_addr;
   logic [KIND_W-1:0] dp_kind;
   logic [DIR_W-1:0]  dp_mask;
   seq_ctl_type       ctl;

   // Dimension registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         dim_x_ff <= DIM_W'(MAX_DIM);
         dim_y_ff <= DIM_W'(MAX_DIM);
         dim_z_ff <= DIM_W'(MAX_DIM);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIM_X: dim_x_ff <= csr_wdata;
            CSR_DIM_Y: dim_y_ff <= csr_wdata;
            CSR_DIM_Z: dim_z_ff <= csr_wdata;
            default:   dim_x_ff <= dim_x_ff;
         endcase
      end
   end

   // A size of zero acts as one, anything above the grid limit as the limit.
   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
      logic [DIM_W-1:0] r;
      r = d;
      if (d == '0) r = DIM_W'(1);
      else if (d > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
      return r;
   endfunction

   assign eff_x = eff_dim(dim_x_ff);
   assign eff_y = eff_dim(dim_y_ff);
   assign eff_z = eff_dim(dim_z_ff);

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   mnbc_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .fin        (fin),
      .out_free   (out_free),
      .ready      (req_tready),
      .push       (push),
      .ctl        (ctl)
   );

   mnbc_datapath u_dp (
      .clock       (clock),
      .ctl         (ctl),
      .req_command (req_tuser),
      .req_x       (req_tdata[5:0]),
      .req_y       (req_tdata[11:6]),
      .req_z       (req_tdata[17:12]),
      .req_flag    (req_tdata[18]),
      .dim_x       (eff_x),
      .dim_y       (eff_y),
      .dim_z       (eff_z),
      .rd_data     (ram_rdata),
      .wr_en       (ram_we),
      .addr        (ram_addr),
      .wr_data     (ram_wdata),
      .fin         (fin),
      .kind        (dp_kind),
      .mask        (dp_mask)
   );

   mnbc_map_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   // Response output register.
   assign rsp_tvalid_in = push || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_kind_ff <= dp_kind;
         rsp_mask_ff <= dp_mask;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = {2'b00, rsp_mask_ff};

endmodule

### rtl/core/mnbc_checker.sv
// ---------------------------------------------------------------------------
// Mesh node boundary classifier checker
// Port-level properties of the request and response channels.
// ---------------------------------------------------------------------------
module mnbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [7:0]                    rsp_tdata,
   input logic [mnbc_pkg::KIND_W-1:0]   rsp_tuser
);
   import mnbc_pkg::*;

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Only a single boundary direction carries a nonzero mask.
   a_mask_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != KIND_SINGLE) |-> rsp_tdata == 8'd0)
      else $error("mask set on a response that is not a single direction");

   // A single direction names one to three axes, never both sides of one axis.
   a_mask_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_SINGLE) |->
         ($countones(rsp_tdata) >= 1) && ($countones(rsp_tdata) <= 3) &&
         !(rsp_tdata[0] && rsp_tdata[1]) && !(rsp_tdata[2] && rsp_tdata[3]) &&
         !(rsp_tdata[4] && rsp_tdata[5]))
      else $error("malformed direction mask");

   // The block works on one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind mesh_node_boundary_classifier mnbc_checker u_mnbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/tb_mesh_node_boundary_classifier.sv
// ---------------------------------------------------------------------------
// Mesh node boundary classifier testbench
// Loads inside flags into grids of many sizes and classifies nodes against
// them. A scoreboard predicts every response from its own copy of the grid
// and the sizes, and checks responses in order while both stream sides idle
// and stall at random.
// ---------------------------------------------------------------------------
module tb_mesh_node_boundary_classifier;
   import mnbc_pkg::*;

   localparam int CLK_PERIOD      = 10;
   localparam int CYCLE_LIMIT     = 2_000_000;
   localparam int SETTLE_CYCLES   = 8;
   localparam int DRAIN_CYCLES    = 40;
   localparam int NUM_PHASES      = 16;
   localparam int PHASE_REQUESTS  = 120;
   localparam int MAP_DEPTH       = 1 << ADDR_W;
   // Index just past the last size register; the block must ignore it.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [DIR_W-1:0]  mask;
   } boundary_result_type;

   // Predicts responses from a private copy of the flag grid and sizes.
   class boundary_scoreboard_type;
      bit                  node_flag [MAP_DEPTH];
      int                  dim_eff [3] = '{MAX_DIM, MAX_DIM, MAX_DIM};
      boundary_result_type awaited_results [$];
      int                  errors;
      int                  kind_count [5];

      function int node_addr(int x, int y, int z);
         return x + MAX_DIM * (y + MAX_DIM * z);
      endfunction

      function bit on_grid(int x, int y, int z);
         return x >= 0 && y >= 0 && z >= 0 &&
                x < dim_eff[0] && y < dim_eff[1] && z < dim_eff[2];
      endfunction

      // A size of zero acts as one, anything above the maximum as the maximum.
      function void set_dim(logic [CSR_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
         int d;
         d = (value == 0) ? 1 : (value > MAX_DIM) ? MAX_DIM : int'(value);
         if (idx == CSR_DIM_X) dim_eff[0] = d;
         else if (idx == CSR_DIM_Y) dim_eff[1] = d;
         else if (idx == CSR_DIM_Z) dim_eff[2] = d;
      endfunction

      // Faces win over edges, edges over corners; the first class holding
      // any inside neighbor decides between a single direction and reentrant.
      function boundary_result_type boundary_of(int x, int y, int z);
         boundary_result_type r;
         int                  hits [3];
         logic [DIR_W-1:0]    hit_mask [3];
         int                  order;
         r.kind = KIND_NONE;
         r.mask = '0;
         hits = '{0, 0, 0};
         hit_mask = '{'0, '0, '0};
         if (!on_grid(x, y, z)) return r;
         if (node_flag[node_addr(x, y, z)]) begin
            r.kind = KIND_INSIDE;
            return r;
         end
         for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  order = (dx != 0) + (dy != 0) + (dz != 0);
                  if (order != 0 && on_grid(x + dx, y + dy, z + dz) &&
                      node_flag[node_addr(x + dx, y + dy, z + dz)]) begin
                     hits[order-1]++;
                     hit_mask[order-1] = ((dx < 0) ? DIR_NX : '0) | ((dx > 0) ? DIR_PX : '0) |
                                         ((dy < 0) ? DIR_NY : '0) | ((dy > 0) ? DIR_PY : '0) |
                                         ((dz < 0) ? DIR_NZ : '0) | ((dz > 0) ? DIR_PZ : '0);
                  end
               end
            end
         end
         for (int c = 0; c < 3; c++) begin
            if (hits[c] == 1) begin
               r.kind = KIND_SINGLE;
               r.mask = hit_mask[c];
               return r;
            end else if (hits[c] > 1) begin
               r.kind = KIND_REENTRANT;
               return r;
            end
         end
         return r;
      endfunction

      function void note_request(logic cmd, int x, int y, int z, logic flag);
         boundary_result_type r;
         if (cmd == CMD_LOAD) begin
            if (on_grid(x, y, z)) node_flag[node_addr(x, y, z)] = flag;
            r.kind = KIND_LOAD_DONE;
            r.mask = '0;
         end else begin
            r = boundary_of(x, y, z);
         end
         awaited_results.push_back(r);
      endfunction

      function void check_response(logic [KIND_W-1:0] kind, logic [7:0] data);
         boundary_result_type r;
         if (awaited_results.size() == 0) begin
            $display("%0t: response with nothing expected: kind %0d data %h",
                     $time, kind, data);
            errors++;
            return;
         end
         r = awaited_results.pop_front();
         kind_count[r.kind]++;
         if (kind !== r.kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d", $time, r.kind, kind);
            errors++;
         end
         if (data !== 8'(r.mask)) begin
            $display("%0t: direction mask mismatch: expected %h, actual %h",
                     $time, 8'(r.mask), data);
            errors++;
         end
      endfunction

      function int awaited();
         return awaited_results.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [23:0]           req_tdata = '0;  // node_x[5:0], node_y[11:6], node_z[17:12],
                                           // inside_flag[18]
   logic                  req_tuser = 1'b0;  // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [7:0]            rsp_tdata;  // direction_mask[5:0]
   logic [KIND_W-1:0]     rsp_tuser;  // kind
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DIM_W-1:0]      csr_wdata = '0;

   boundary_scoreboard_type sb = new;
   bit                      node_loaded [MAP_DEPTH];
   int                      req_idle_pct = 0;
   int                      rsp_stall_pct = 0;
   int                      load_density = 0;
   int                      requests_sent = 0;
   int unsigned             cycle_count = 0;

   mesh_node_boundary_classifier DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Receiver stalls at random with the current stall rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Outputs are stable from the falling edge up to the accepting rising edge.
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tuser, rsp_tdata);
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Run stopped after %0d cycles with %0d responses outstanding",
               cycle_count, sb.awaited());
      $display("Test completed with failures");
      $finish;
   end

   // Presents one request and returns at the edge that accepts it.
   task automatic send_request(input logic cmd, input int x, input int y, input int z,
                               input logic flag);
      int gap;
      gap = 0;
      while ($urandom_range(99) < req_idle_pct) gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, flag, COORD_W'(z), COORD_W'(y), COORD_W'(x)};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      sb.note_request(cmd, x, y, z, flag);
      requests_sent++;
   endtask

   task automatic load_node(input int x, input int y, input int z, input logic flag);
      send_request(CMD_LOAD, x, y, z, flag);
      if (sb.on_grid(x, y, z)) node_loaded[sb.node_addr(x, y, z)] = 1'b1;
   endtask

   // The node and every neighbor on the grid get a flag before the classify.
   task automatic classify_node(input int x, input int y, input int z);
      if (sb.on_grid(x, y, z)) begin
         for (int dz = -1; dz <= 1; dz++) begin
            for (int dy = -1; dy <= 1; dy++) begin
               for (int dx = -1; dx <= 1; dx++) begin
                  if (sb.on_grid(x + dx, y + dy, z + dz) &&
                      !node_loaded[sb.node_addr(x + dx, y + dy, z + dz)])
                     load_node(x + dx, y + dy, z + dz, $urandom_range(99) < load_density);
               end
            end
         end
      end
      send_request(CMD_CLASSIFY, x, y, z, 1'($urandom_range(1)));
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      sb.set_dim(idx, value);
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [DIM_W-1:0] sx, input logic [DIM_W-1:0] sy,
                           input logic [DIM_W-1:0] sz);
      write_reg(CSR_DIM_X, sx);
      write_reg(CSR_DIM_Y, sy);
      write_reg(CSR_DIM_Z, sz);
      if ($urandom_range(2) == 0) write_reg(CSR_UNUSED, DIM_W'($urandom_range(127)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Waits until every response is in, then lets the block settle.
   task automatic wait_idle(input int settle);
      req_tvalid <= 1'b0;
      while (sb.awaited() > 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   // Mostly small sizes, with zero, the maximum and values above it now and then.
   function automatic logic [DIM_W-1:0] pick_size();
      case ($urandom_range(9))
         0: return '0;
         1: return DIM_W'($urandom_range(MAX_DIM + 1, 127));
         2: return DIM_W'(MAX_DIM);
         3: return DIM_W'($urandom_range(7, MAX_DIM));
         default: return DIM_W'($urandom_range(1, 6));
      endcase
   endfunction

   initial begin
      int phase_start;
      int pick;
      int densities [5];
      densities = '{3, 10, 25, 50, 90};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);

      // Directed: a 2x2x2 grid, all outside, then inside nodes added one by
      // one so that each neighbor class decides in turn.
      set_grid(DIM_W'(2), DIM_W'(2), DIM_W'(2));
      for (int z = 0; z < 2; z++)
         for (int y = 0; y < 2; y++)
            for (int x = 0; x < 2; x++)
               load_node(x, y, z, 1'b0);
      classify_node(0, 0, 0);        // no inside neighbor
      load_node(1, 1, 1, 1'b1);
      classify_node(0, 0, 0);        // single corner
      load_node(1, 1, 0, 1'b1);
      classify_node(0, 0, 0);        // single edge beats the corner
      load_node(1, 0, 1, 1'b1);
      classify_node(0, 0, 0);        // two edges: reentrant
      load_node(0, 0, 1, 1'b1);
      classify_node(0, 0, 0);        // single face beats the edges
      load_node(1, 0, 0, 1'b1);
      classify_node(0, 0, 0);        // two faces: reentrant
      classify_node(0, 0, 1);        // inside node
      load_node(63, 40, 0, 1'b1);    // off the grid: nothing stored
      classify_node(0, 0, 63);       // off the grid: none
      wait_idle(SETTLE_CYCLES);

      // Random phases, each with its own sizes, flag density and idle pattern.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase % 4)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 87; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 87; end
            default: begin req_idle_pct = 32; rsp_stall_pct = 32; end
         endcase
         load_density = densities[$urandom_range(4)];
         if (phase == 0) set_grid('0, DIM_W'(127), DIM_W'(1));
         else if (phase == 1) set_grid(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
         else set_grid(pick_size(), pick_size(), pick_size());
         phase_start = requests_sent;
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            pick = $urandom_range(99);
            if (pick < 35)
               load_node($urandom_range(sb.dim_eff[0] - 1), $urandom_range(sb.dim_eff[1] - 1),
                         $urandom_range(sb.dim_eff[2] - 1), $urandom_range(99) < load_density);
            else if (pick < 85)
               classify_node($urandom_range(sb.dim_eff[0] - 1),
                             $urandom_range(sb.dim_eff[1] - 1),
                             $urandom_range(sb.dim_eff[2] - 1));
            else if (pick < 93)
               load_node($urandom_range(63), $urandom_range(63), $urandom_range(63),
                         1'($urandom_range(1)));
            else
               classify_node($urandom_range(63), $urandom_range(63), $urandom_range(63));
         end
         wait_idle(SETTLE_CYCLES);
      end

      wait_idle(DRAIN_CYCLES);
      $display("Ran %0d requests over %0d grid settings in %0d cycles, with idle and stall",
               requests_sent, NUM_PHASES + 1, cycle_count);
      $display("Responses seen: load %0d, inside %0d, none %0d, reentrant %0d, single %0d",
               sb.kind_count[KIND_LOAD_DONE], sb.kind_count[KIND_INSIDE],
               sb.kind_count[KIND_NONE], sb.kind_count[KIND_REENTRANT],
               sb.kind_count[KIND_SINGLE]);
      if (sb.errors == 0 && sb.awaited() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
